@@ rtl/core/dflm_pkg.sv @@
// Shared types, constants and helpers for the descriptor free-list manager.
// Used by every module of the block; has no dependencies of its own.

package dflm_pkg;

  // Descriptor table depth and the largest queue size the table can serve.
  localparam int TABLE_DEPTH = 256;
  localparam int SIZE_CAP    = (TABLE_DEPTH < 256) ? TABLE_DEPTH : 256;
  localparam int TBL_ENTRIES = SIZE_CAP;
  localparam int IDX_W       = $clog2(TBL_ENTRIES);

  // Fixed field widths of the item and result.
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int ADDR_W   = 64;
  localparam int LEN_W    = 32;
  localparam int COUNT_W  = 9;
  localparam int PTR_W    = 16;
  localparam int FLAGS_W  = 2;

  localparam logic [PTR_W-1:0] NONE = 16'hFFFF;

  // Bit positions in the descriptor flags.
  localparam int FLAG_NEXT  = 0;
  localparam int FLAG_WRITE = 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD  = 2'd0,
    MODE_FREE = 2'd1,
    MODE_POP  = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_CLEAR,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [ADDR_W-1:0]  buf_addr;
    logic [LEN_W-1:0]   buf_len;
    logic               dev_wr;
    logic [COUNT_W-1:0] chain_count;
    logic               last_buf;
    logic [PTR_W-1:0]   free_index;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PTR_W-1:0]    desc_index;
    logic [PTR_W-1:0]    chain_head;
    logic [COUNT_W-1:0]  free_total;
  } result_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [LEN_W-1:0]   len;
    logic [FLAGS_W-1:0] flags;
    logic [PTR_W-1:0]   link;
  } entry_t;

  // One request per cycle to the descriptor table.
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    entry_t           wr_entry;
  } tbl_req_t;

  // A recorded step of a chain walk: which entry, and the link it gets.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [PTR_W-1:0] link;
  } walk_rec_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    walk_rec_t        wr_rec;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } wb_req_t;

  // Size actually in effect: zero counts as one, large values saturate.
  function automatic logic [COUNT_W-1:0] eff_size(input logic [COUNT_W-1:0] q);
    logic [COUNT_W-1:0] s;
    s = q;
    if (s == '0) begin
      s = COUNT_W'(1);
    end
    if (s > COUNT_W'(SIZE_CAP)) begin
      s = COUNT_W'(SIZE_CAP);
    end
    return s;
  endfunction

endpackage

@@ rtl/core/dflm_table.sv @@
// Descriptor table memory with per-entry valid bits and registered read.
// Depends on dflm_pkg for the entry and request types.

module dflm_table (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clear,
  input  logic [dflm_pkg::COUNT_W-1:0] size,
  input  dflm_pkg::tbl_req_t         req,
  output dflm_pkg::entry_t           rd_entry
);

  dflm_pkg::entry_t                     mem [dflm_pkg::TBL_ENTRIES];
  logic [dflm_pkg::TBL_ENTRIES-1:0]     vld;
  dflm_pkg::entry_t                     rd_raw;
  logic                                 rd_vld;
  logic [dflm_pkg::IDX_W-1:0]           rd_idx_q;
  logic [dflm_pkg::PTR_W-1:0]           init_next;
  dflm_pkg::entry_t                     init_entry;

  // The controller never reads and writes in the same cycle, so no bypass.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_idx] <= req.wr_entry;
    end
    if (req.rd_en) begin
      rd_raw   <= mem[req.rd_idx];
      rd_vld   <= vld[req.rd_idx];
      rd_idx_q <= req.rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      vld <= '0;
    end else if (req.wr_en) begin
      vld[req.wr_idx] <= 1'b1;
    end
  end

  // An entry not written since the last rebuild reads as its initial free-list form.
  always_comb begin
    init_next        = dflm_pkg::PTR_W'(rd_idx_q) + dflm_pkg::PTR_W'(1);
    init_entry       = '0;
    init_entry.link  = (init_next < dflm_pkg::PTR_W'(size)) ? init_next : dflm_pkg::NONE;
    rd_entry         = rd_vld ? rd_raw : init_entry;
  end

endmodule

@@ rtl/core/dflm_walk_buf.sv @@
// Walk buffer: records each step of a chain walk for the later write-back pass.
// Depends on dflm_pkg for the record and request types.

module dflm_walk_buf (
  input  logic                clk,
  input  dflm_pkg::wb_req_t   req,
  output dflm_pkg::walk_rec_t rd_rec
);

  dflm_pkg::walk_rec_t mem [dflm_pkg::TBL_ENTRIES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_rec;
    end
    if (req.rd_en) begin
      rd_rec <= mem[req.rd_addr];
    end
  end

endmodule

@@ rtl/core/dflm_ctrl.sv @@
// Sequencer for the free-list manager: list head, free counter, chain state,
// and the add, take and free operations. Depends on dflm_pkg.

module dflm_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rebuild,
  input  logic [dflm_pkg::COUNT_W-1:0] rebuild_size,
  input  logic [dflm_pkg::COUNT_W-1:0] size,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  dflm_pkg::item_t              in_item,
  input  logic                         slot_free,
  output logic                         res_valid,
  output dflm_pkg::result_t            res,
  output dflm_pkg::tbl_req_t           tbl_req,
  input  dflm_pkg::entry_t             tbl_rd,
  output dflm_pkg::wb_req_t            wb_req,
  input  dflm_pkg::walk_rec_t          wb_rd
);

  localparam int CW = dflm_pkg::COUNT_W;
  localparam int PW = dflm_pkg::PTR_W;
  localparam int IW = dflm_pkg::IDX_W;

  dflm_pkg::state_t state, state_next;

  logic [PW-1:0] list_head;
  logic [CW-1:0] free_counter;
  logic          in_chain;
  logic          chain_rejected;
  logic [PW-1:0] current_head;

  dflm_pkg::item_t it;
  logic [PW-1:0]   exec_head;
  logic [IW-1:0]   walk_cur;
  logic [CW-1:0]   walk_n;
  logic [CW-1:0]   walk_total;
  logic [CW-1:0]   clr_j;
  logic            wb_rd_vld;

  logic          can_accept, accept;
  logic [PW-1:0] size_ext;
  logic          head_valid;
  logic          first, add_rej, add_go;
  logic [PW-1:0] add_head;
  logic          free_go, go_exec, go_walk;
  dflm_pkg::result_t imm_res, exec_res, free_res;
  logic [CW-1:0] fc_dec;
  logic [CW:0]   fc_sum;
  logic [CW-1:0] fc_free;
  logic [PW-1:0] walk_nx;
  logic [CW-1:0] walk_n1;
  logic          walk_cont;
  logic          clr_issue, clr_done;

  assign size_ext   = PW'(size);
  assign head_valid = list_head < size_ext;
  assign can_accept = !rebuild && ((state == dflm_pkg::ST_IDLE) ||
                                   (state == dflm_pkg::ST_RESP && slot_free));
  assign accept     = in_valid && can_accept;

  // Decisions for a newly arriving item; none of them needs the table.
  always_comb begin
    first    = !in_chain;
    add_rej  = first ? ((in_item.chain_count == '0) || !head_valid ||
                        (free_counter < in_item.chain_count))
                     : chain_rejected;
    add_head = first ? (add_rej ? dflm_pkg::NONE : list_head) : current_head;
    add_go   = !add_rej && head_valid;
    free_go  = (in_item.free_index != dflm_pkg::NONE) && (in_item.free_index < size_ext);

    imm_res            = '0;
    imm_res.status     = dflm_pkg::STATUS_OK;
    imm_res.desc_index = dflm_pkg::NONE;
    imm_res.chain_head = dflm_pkg::NONE;
    imm_res.free_total = free_counter;
    go_exec            = 1'b0;
    go_walk            = 1'b0;

    unique case (in_item.mode)
      dflm_pkg::MODE_ADD: begin
        go_exec = add_go;
        if (add_rej) begin
          imm_res.status = dflm_pkg::STATUS_EMPTY;
        end else begin
          // The free list ran dry partway through the chain.
          imm_res.status     = dflm_pkg::STATUS_EMPTY;
          imm_res.chain_head = add_head;
        end
      end
      dflm_pkg::MODE_FREE: begin
        go_walk = free_go;
        if (in_item.free_index != dflm_pkg::NONE) begin
          imm_res.status = dflm_pkg::STATUS_RANGE;
        end
      end
      dflm_pkg::MODE_POP: begin
        go_exec = head_valid;
        imm_res.status = dflm_pkg::STATUS_EMPTY;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    fc_dec  = (free_counter != '0) ? (free_counter - CW'(1)) : free_counter;
    fc_sum  = {1'b0, free_counter} + {1'b0, walk_total};
    fc_free = (fc_sum > (CW+1)'(size)) ? size : fc_sum[CW-1:0];

    exec_res            = '0;
    exec_res.status     = dflm_pkg::STATUS_OK;
    exec_res.desc_index = list_head;
    exec_res.chain_head = (it.mode == dflm_pkg::MODE_ADD) ? exec_head : dflm_pkg::NONE;
    exec_res.free_total = fc_dec;

    free_res            = '0;
    free_res.status     = dflm_pkg::STATUS_OK;
    free_res.desc_index = it.free_index;
    free_res.chain_head = dflm_pkg::NONE;
    free_res.free_total = fc_free;

    walk_nx   = tbl_rd.flags[dflm_pkg::FLAG_NEXT] ? tbl_rd.link : dflm_pkg::NONE;
    walk_n1   = walk_n + CW'(1);
    walk_cont = (walk_nx < size_ext) && (walk_n1 < size);

    clr_issue = clr_j < walk_total;
    clr_done  = !clr_issue && wb_rd_vld;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dflm_pkg::ST_IDLE,
      dflm_pkg::ST_RESP: begin
        if (accept) begin
          if (go_exec) begin
            state_next = dflm_pkg::ST_EXEC;
          end else if (go_walk) begin
            state_next = dflm_pkg::ST_WALK;
          end else begin
            state_next = dflm_pkg::ST_RESP;
          end
        end else if (state == dflm_pkg::ST_RESP && slot_free) begin
          state_next = dflm_pkg::ST_IDLE;
        end
      end
      dflm_pkg::ST_EXEC: begin
        state_next = dflm_pkg::ST_RESP;
      end
      dflm_pkg::ST_WALK: begin
        if (!walk_cont) begin
          state_next = dflm_pkg::ST_CLEAR;
        end
      end
      dflm_pkg::ST_CLEAR: begin
        if (clr_done) begin
          state_next = dflm_pkg::ST_RESP;
        end
      end
      default: begin
        state_next = dflm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall  = !can_accept;
    res_valid = (state == dflm_pkg::ST_RESP);
    tbl_req   = '0;
    wb_req    = '0;
    unique case (state)
      dflm_pkg::ST_IDLE,
      dflm_pkg::ST_RESP: begin
        if (accept && go_exec) begin
          tbl_req.rd_en  = 1'b1;
          tbl_req.rd_idx = list_head[IW-1:0];
        end else if (accept && go_walk) begin
          tbl_req.rd_en  = 1'b1;
          tbl_req.rd_idx = in_item.free_index[IW-1:0];
        end
      end
      dflm_pkg::ST_EXEC: begin
        if (it.mode == dflm_pkg::MODE_ADD) begin
          tbl_req.wr_en          = 1'b1;
          tbl_req.wr_idx         = list_head[IW-1:0];
          tbl_req.wr_entry.addr  = it.buf_addr;
          tbl_req.wr_entry.len   = it.buf_len;
          tbl_req.wr_entry.flags[dflm_pkg::FLAG_WRITE] = it.dev_wr;
          tbl_req.wr_entry.flags[dflm_pkg::FLAG_NEXT]  = !it.last_buf;
          tbl_req.wr_entry.link  = it.last_buf ? dflm_pkg::NONE : tbl_rd.link;
        end
      end
      dflm_pkg::ST_WALK: begin
        // Record the link this entry will get; the table itself is not touched yet,
        // so a chain that revisits an entry still sees its original flags.
        wb_req.wr_en       = 1'b1;
        wb_req.wr_addr     = walk_n[IW-1:0];
        wb_req.wr_rec.idx  = walk_cur;
        wb_req.wr_rec.link = walk_cont ? walk_nx : list_head;
        if (walk_cont) begin
          tbl_req.rd_en  = 1'b1;
          tbl_req.rd_idx = walk_nx[IW-1:0];
        end
      end
      dflm_pkg::ST_CLEAR: begin
        wb_req.rd_en   = clr_issue;
        wb_req.rd_addr = clr_j[IW-1:0];
        if (wb_rd_vld) begin
          tbl_req.wr_en         = 1'b1;
          tbl_req.wr_idx        = wb_rd.idx;
          tbl_req.wr_entry      = '0;
          tbl_req.wr_entry.link = wb_rd.link;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= dflm_pkg::ST_IDLE;
      list_head      <= '0;
      free_counter   <= CW'(dflm_pkg::SIZE_CAP);
      in_chain       <= 1'b0;
      chain_rejected <= 1'b0;
      current_head   <= dflm_pkg::NONE;
      wb_rd_vld      <= 1'b0;
    end else if (rebuild) begin
      list_head      <= '0;
      free_counter   <= rebuild_size;
      in_chain       <= 1'b0;
      chain_rejected <= 1'b0;
      current_head   <= dflm_pkg::NONE;
      wb_rd_vld      <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && in_item.mode == dflm_pkg::MODE_ADD) begin
        in_chain       <= !in_item.last_buf;
        chain_rejected <= !in_item.last_buf && !add_go;
        current_head   <= in_item.last_buf ? dflm_pkg::NONE : add_head;
      end
      unique case (state)
        dflm_pkg::ST_EXEC: begin
          list_head    <= tbl_rd.link;
          free_counter <= fc_dec;
        end
        dflm_pkg::ST_WALK: begin
          wb_rd_vld <= 1'b0;
        end
        dflm_pkg::ST_CLEAR: begin
          wb_rd_vld <= clr_issue;
          if (clr_done) begin
            list_head    <= it.free_index;
            free_counter <= fc_free;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it        <= in_item;
      exec_head <= add_head;
      walk_cur  <= in_item.free_index[IW-1:0];
      walk_n    <= '0;
      if (!go_exec && !go_walk) begin
        res <= imm_res;
      end
    end
    unique case (state)
      dflm_pkg::ST_EXEC: begin
        res <= exec_res;
      end
      dflm_pkg::ST_WALK: begin
        if (walk_cont) begin
          walk_cur <= walk_nx[IW-1:0];
          walk_n   <= walk_n1;
        end else begin
          walk_total <= walk_n1;
          clr_j      <= '0;
        end
      end
      dflm_pkg::ST_CLEAR: begin
        if (clr_issue) begin
          clr_j <= clr_j + CW'(1);
        end
        if (clr_done) begin
          res <= free_res;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/descriptor_free_list_manager_core.sv @@
// Top level of the descriptor free-list manager: size register, output register,
// and the sequencer with its two memories. Depends on dflm_pkg, dflm_table,
// dflm_walk_buf and dflm_ctrl.

// The block manages a descriptor table kept in one synchronous memory and hands
// out entries from a linked free list. Adding a chain element or taking a single
// descriptor works as follows: the item is accepted while the head entry is read,
// and the next cycle writes an added element back and advances the list head.
// Requests answered without the table (rejected chain elements, empty list, index
// out of range, freeing of index 0xFFFF, unused mode 3) go straight to the response
// state. Freeing a chain walks it: the walk reads one table entry per cycle and
// logs it in a walk buffer, then a second pass writes one cleared entry per cycle
// from that log. Results wait in an output register, so the next item is taken
// while the previous result is still pending. Writing the size register rebuilds
// the list by resetting valid bits, head and free counter; there is no clearing pass.

module descriptor_free_list_manager_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [dflm_pkg::COUNT_W-1:0]  cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dflm_pkg::MODE_W-1:0]   mode,
  input  logic [dflm_pkg::ADDR_W-1:0]   buf_addr,
  input  logic [dflm_pkg::LEN_W-1:0]    buf_len,
  input  logic                          dev_wr,
  input  logic [dflm_pkg::COUNT_W-1:0]  chain_count,
  input  logic                          last_buf,
  input  logic [dflm_pkg::PTR_W-1:0]    free_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dflm_pkg::STATUS_W-1:0] status,
  output logic [dflm_pkg::PTR_W-1:0]    desc_index,
  output logic [dflm_pkg::PTR_W-1:0]    chain_head,
  output logic [dflm_pkg::COUNT_W-1:0]  free_total
);

  logic [dflm_pkg::COUNT_W-1:0] size;
  logic [dflm_pkg::COUNT_W-1:0] new_size;
  dflm_pkg::item_t              in_item;
  dflm_pkg::result_t            res;
  dflm_pkg::result_t            out_res;
  logic                         res_valid;
  logic                         slot_free;
  dflm_pkg::tbl_req_t           tbl_req;
  dflm_pkg::entry_t             tbl_rd;
  dflm_pkg::wb_req_t            wb_req;
  dflm_pkg::walk_rec_t          wb_rd;

  assign new_size = dflm_pkg::eff_size(cfg_wr_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      size <= dflm_pkg::COUNT_W'(dflm_pkg::SIZE_CAP);
    end else if (cfg_wr_en) begin
      size <= new_size;
    end
  end

  always_comb begin
    in_item.mode        = mode;
    in_item.buf_addr    = buf_addr;
    in_item.buf_len     = buf_len;
    in_item.dev_wr      = dev_wr;
    in_item.chain_count = chain_count;
    in_item.last_buf    = last_buf;
    in_item.free_index  = free_index;
  end

  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && slot_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && slot_free) begin
      out_res <= res;
    end
  end

  assign status     = out_res.status;
  assign desc_index = out_res.desc_index;
  assign chain_head = out_res.chain_head;
  assign free_total = out_res.free_total;

  dflm_table u_table (
    .clk      (clk),
    .rst      (rst),
    .clear    (cfg_wr_en),
    .size     (size),
    .req      (tbl_req),
    .rd_entry (tbl_rd)
  );

  dflm_walk_buf u_walk_buf (
    .clk    (clk),
    .req    (wb_req),
    .rd_rec (wb_rd)
  );

  dflm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .rebuild      (cfg_wr_en),
    .rebuild_size (new_size),
    .size         (size),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_item      (in_item),
    .slot_free    (slot_free),
    .res_valid    (res_valid),
    .res          (res),
    .tbl_req      (tbl_req),
    .tbl_rd       (tbl_rd),
    .wb_req       (wb_req),
    .wb_rd        (wb_rd)
  );

endmodule

@@ dv/tb_descriptor_free_list_manager_core.sv @@
// Self-checking testbench for descriptor_free_list_manager_core: directed corner cases,
// an output hold-off that backs up the input, and random chain traffic at several sizes.
// Depends on dflm_pkg and the RTL of the block; results are checked by a table predictor.

module tb_descriptor_free_list_manager_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [dflm_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int PRINT_CAP   = 60;

  logic                          clk;
  logic                          rst         = 1'b1;
  logic                          cfg_wr_en   = 1'b0;
  logic [dflm_pkg::COUNT_W-1:0]  cfg_wr_data = '0;
  logic                          in_valid    = 1'b0;
  logic                          in_stall;
  logic [dflm_pkg::MODE_W-1:0]   mode        = '0;
  logic [dflm_pkg::ADDR_W-1:0]   buf_addr    = '0;
  logic [dflm_pkg::LEN_W-1:0]    buf_len     = '0;
  logic                          dev_wr      = 1'b0;
  logic [dflm_pkg::COUNT_W-1:0]  chain_count = '0;
  logic                          last_buf    = 1'b0;
  logic [dflm_pkg::PTR_W-1:0]    free_index  = '0;
  logic                          out_valid;
  logic                          out_stall   = 1'b0;
  logic [dflm_pkg::STATUS_W-1:0] status;
  logic [dflm_pkg::PTR_W-1:0]    desc_index;
  logic [dflm_pkg::PTR_W-1:0]    chain_head;
  logic [dflm_pkg::COUNT_W-1:0]  free_total;

  descriptor_free_list_manager_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .buf_addr    (buf_addr),
    .buf_len     (buf_len),
    .dev_wr      (dev_wr),
    .chain_count (chain_count),
    .last_buf    (last_buf),
    .free_index  (free_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .desc_index  (desc_index),
    .chain_head  (chain_head),
    .free_total  (free_total)
  );

  // Predicted descriptor table and list state.
  logic [dflm_pkg::ADDR_W-1:0]  tbl_addr  [dflm_pkg::TABLE_DEPTH];
  logic [dflm_pkg::LEN_W-1:0]   tbl_len   [dflm_pkg::TABLE_DEPTH];
  logic [dflm_pkg::FLAGS_W-1:0] tbl_flags [dflm_pkg::TABLE_DEPTH];
  logic [dflm_pkg::PTR_W-1:0]   tbl_link  [dflm_pkg::TABLE_DEPTH];
  logic [dflm_pkg::PTR_W-1:0]   pred_head;
  int                           free_count;
  logic                         adding;
  logic                         add_rejected;
  logic [dflm_pkg::PTR_W-1:0]   add_head;
  logic [dflm_pkg::COUNT_W-1:0] qsize;

  dflm_pkg::result_t          pending_results [$];
  logic [dflm_pkg::PTR_W-1:0] live_chains [$];

  int items_sent      = 0;
  int results_checked = 0;
  int error_count     = 0;
  int sizes_used      = 1;
  int count_ok        = 0;
  int count_empty     = 0;
  int count_range     = 0;
  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  int hold_left       = 0;
  int quiet_cycles    = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int active_size();
    int s;
    s = int'(qsize);
    if (s == 0) begin
      s = 1;
    end
    if (s > dflm_pkg::SIZE_CAP) begin
      s = dflm_pkg::SIZE_CAP;
    end
    return s;
  endfunction

  function automatic void rebuild_table(input logic [dflm_pkg::COUNT_W-1:0] v);
    int s;
    int i;
    qsize = v;
    s = active_size();
    for (i = 0; i < dflm_pkg::TABLE_DEPTH; i++) begin
      tbl_addr[i]  = '0;
      tbl_len[i]   = '0;
      tbl_flags[i] = '0;
      tbl_link[i]  = (i + 1 < s) ? dflm_pkg::PTR_W'(i + 1) : dflm_pkg::NONE;
    end
    pred_head    = '0;
    free_count   = s;
    adding       = 1'b0;
    add_rejected = 1'b0;
    add_head     = dflm_pkg::NONE;
  endfunction

  function automatic bit head_ok();
    return pred_head != dflm_pkg::NONE && int'(pred_head) < active_size();
  endfunction

  function automatic dflm_pkg::result_t table_step(input dflm_pkg::item_t it);
    dflm_pkg::result_t          r;
    int                         s;
    int                         n;
    int                         cur;
    int                         nx;
    int                         i;
    int                         idx;
    int                         trail [dflm_pkg::TABLE_DEPTH];
    logic [dflm_pkg::PTR_W-1:0] nxt;
    s = active_size();
    r.status     = dflm_pkg::STATUS_OK;
    r.desc_index = dflm_pkg::NONE;
    r.chain_head = dflm_pkg::NONE;
    r.free_total = '0;
    case (it.mode)
      dflm_pkg::MODE_ADD: begin
        if (!adding) begin
          adding       = 1'b1;
          add_head     = dflm_pkg::NONE;
          add_rejected = (it.chain_count == 0) || !head_ok() ||
                         (free_count < int'(it.chain_count));
          if (!add_rejected) begin
            add_head = pred_head;
          end
        end
        if (!add_rejected && !head_ok()) begin
          // The list ran dry part way through an accepted chain.
          add_rejected = 1'b1;
          r.status     = dflm_pkg::STATUS_EMPTY;
          r.chain_head = add_head;
        end else if (add_rejected) begin
          r.status = dflm_pkg::STATUS_EMPTY;
        end else begin
          idx            = int'(pred_head);
          nxt            = tbl_link[idx];
          tbl_addr[idx]  = it.buf_addr;
          tbl_len[idx]   = it.buf_len;
          tbl_flags[idx] = '0;
          tbl_flags[idx][dflm_pkg::FLAG_WRITE] = it.dev_wr;
          tbl_flags[idx][dflm_pkg::FLAG_NEXT]  = !it.last_buf;
          tbl_link[idx]  = it.last_buf ? dflm_pkg::NONE : nxt;
          pred_head      = nxt;
          if (free_count > 0) begin
            free_count--;
          end
          r.desc_index = dflm_pkg::PTR_W'(idx);
          r.chain_head = add_head;
        end
        if (it.last_buf) begin
          adding       = 1'b0;
          add_rejected = 1'b0;
          add_head     = dflm_pkg::NONE;
        end
      end
      dflm_pkg::MODE_FREE: begin
        if (it.free_index == dflm_pkg::NONE) begin
          r.status = dflm_pkg::STATUS_OK;
        end else if (int'(it.free_index) >= s) begin
          r.status = dflm_pkg::STATUS_RANGE;
        end else begin
          n   = 0;
          cur = int'(it.free_index);
          while (cur != int'(dflm_pkg::NONE) && cur < s && n < s) begin
            nx       = tbl_flags[cur][dflm_pkg::FLAG_NEXT] ? int'(tbl_link[cur])
                                                          : int'(dflm_pkg::NONE);
            trail[n] = cur;
            n++;
            cur = nx;
          end
          for (i = 0; i < n; i++) begin
            tbl_flags[trail[i]] = '0;
            tbl_len[trail[i]]   = '0;
            tbl_addr[trail[i]]  = '0;
            tbl_link[trail[i]]  = (i + 1 < n) ? dflm_pkg::PTR_W'(trail[i + 1]) : pred_head;
          end
          pred_head    = dflm_pkg::PTR_W'(trail[0]);
          free_count   = (free_count + n > s) ? s : free_count + n;
          r.desc_index = it.free_index;
        end
      end
      dflm_pkg::MODE_POP: begin
        if (!head_ok()) begin
          r.status = dflm_pkg::STATUS_EMPTY;
        end else begin
          r.desc_index = pred_head;
          pred_head    = tbl_link[pred_head];
          if (free_count > 0) begin
            free_count--;
          end
        end
      end
      default: begin
        r.status = dflm_pkg::STATUS_OK;
      end
    endcase
    r.free_total = dflm_pkg::COUNT_W'(free_count);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_CAP) begin
      $display("[%0t] mismatch on result %0d: %s", $time, results_checked, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      report_mismatch($sformatf("%s expected %0h, got %0h", name, want, got));
    end
  endtask

  always @(posedge clk) begin : result_check
    dflm_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected item, status %0d desc_index %0h",
                                  status, desc_index));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        case (want.status)
          dflm_pkg::STATUS_OK:    count_ok++;
          dflm_pkg::STATUS_EMPTY: count_empty++;
          default:                count_range++;
        endcase
        check_field("status", 64'(want.status), 64'(status));
        check_field("desc_index", 64'(want.desc_index), 64'(desc_index));
        check_field("chain_head", 64'(want.chain_head), 64'(chain_head));
        check_field("free_total", 64'(want.free_total), 64'(free_total));
      end
    end
  end

  // Result side: a requested hold-off is counted down here, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: %0d cycles without a handshake, %0d results outstanding",
               quiet_cycles, pending_results.size());
      $display("tb_descriptor_free_list_manager_core: done, errors");
      $finish;
    end
  end

  // Valid stays high after acceptance; the next call either offers a new item or
  // lowers it at the following falling edge.
  task automatic send_item(input dflm_pkg::item_t it, output dflm_pkg::result_t exp);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= it.mode;
    buf_addr    <= it.buf_addr;
    buf_len     <= it.buf_len;
    dev_wr      <= it.dev_wr;
    chain_count <= it.chain_count;
    last_buf    <= it.last_buf;
    free_index  <= it.free_index;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    exp = table_step(it);
    pending_results.push_back(exp);
    items_sent++;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic write_size_reg(input logic [dflm_pkg::COUNT_W-1:0] v);
    wait_for_results();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    rebuild_table(v);
    live_chains.delete();
    sizes_used++;
  endtask

  function automatic dflm_pkg::item_t any_item();
    dflm_pkg::item_t it;
    it.mode        = dflm_pkg::MODE_W'($urandom_range(2));
    it.buf_addr    = {$urandom, $urandom};
    it.buf_len     = $urandom;
    it.dev_wr      = 1'($urandom_range(1));
    it.chain_count = dflm_pkg::COUNT_W'($urandom_range(256));
    it.last_buf    = 1'($urandom_range(1));
    it.free_index  = dflm_pkg::PTR_W'($urandom);
    return it;
  endfunction

  task automatic do_add(input int cc, input logic last, output dflm_pkg::result_t r);
    dflm_pkg::item_t it;
    it             = any_item();
    it.mode        = dflm_pkg::MODE_ADD;
    it.chain_count = dflm_pkg::COUNT_W'(cc);
    it.last_buf    = last;
    send_item(it, r);
  endtask

  task automatic do_free(input logic [dflm_pkg::PTR_W-1:0] idx,
                         output dflm_pkg::result_t r);
    dflm_pkg::item_t it;
    it            = any_item();
    it.mode       = dflm_pkg::MODE_FREE;
    it.free_index = idx;
    send_item(it, r);
  endtask

  task automatic do_pop(output dflm_pkg::result_t r);
    dflm_pkg::item_t it;
    it      = any_item();
    it.mode = dflm_pkg::MODE_POP;
    send_item(it, r);
    if (r.status == dflm_pkg::STATUS_OK) begin
      live_chains.push_back(r.desc_index);
    end
  endtask

  task automatic add_chain(input int k, input int cc);
    dflm_pkg::result_t          r;
    dflm_pkg::result_t          side;
    logic [dflm_pkg::PTR_W-1:0] head;
    int                         i;
    head = dflm_pkg::NONE;
    for (i = 0; i < k; i++) begin
      if (i > 0 && $urandom_range(19) == 0) begin
        do_pop(side);
      end
      do_add(cc, (i == k - 1), r);
      if (r.chain_head != dflm_pkg::NONE) begin
        head = r.chain_head;
      end
    end
    if (head != dflm_pkg::NONE) begin
      live_chains.push_back(head);
    end
  endtask

  task automatic free_live();
    dflm_pkg::result_t          r;
    int                         pos;
    logic [dflm_pkg::PTR_W-1:0] idx;
    if (live_chains.size() == 0) begin
      idx = dflm_pkg::PTR_W'($urandom_range(active_size() - 1));
    end else begin
      pos = $urandom_range(live_chains.size() - 1);
      idx = live_chains[pos];
      live_chains.delete(pos);
    end
    do_free(idx, r);
  endtask

  task automatic send_noise();
    dflm_pkg::item_t   it;
    dflm_pkg::result_t r;
    it = any_item();
    case ($urandom_range(3))
      0: it.mode = dflm_pkg::MODE_FREE;
      1: begin
        // Any index near the table, free or in use, so double frees happen.
        it.mode       = dflm_pkg::MODE_FREE;
        it.free_index = dflm_pkg::PTR_W'($urandom_range(active_size() + 1));
      end
      2: it.mode = MODE_UNUSED;
      default: it.mode = dflm_pkg::MODE_ADD;
    endcase
    send_item(it, r);
  endtask

  task automatic test_reset_defaults();
    dflm_pkg::item_t   it;
    dflm_pkg::result_t r;
    do_pop(r);
    it             = any_item();
    it.mode        = dflm_pkg::MODE_ADD;
    it.buf_addr    = '1;
    it.buf_len     = '1;
    it.dev_wr      = 1'b1;
    it.chain_count = dflm_pkg::COUNT_W'(2);
    it.last_buf    = 1'b0;
    send_item(it, r);
    it.buf_addr    = '0;
    it.buf_len     = '0;
    it.dev_wr      = 1'b0;
    it.last_buf    = 1'b1;
    send_item(it, r);
    do_free(dflm_pkg::PTR_W'(1), r);
    do_free(dflm_pkg::NONE, r);
    do_free(dflm_pkg::PTR_W'(256), r);
    do_free(16'hFFFE, r);
    it      = any_item();
    it.mode = MODE_UNUSED;
    send_item(it, r);
    do_add(0, 1'b1, r);
    do_add(256, 1'b0, r);
    do_add(256, 1'b1, r);
    do_free(dflm_pkg::PTR_W'(0), r);
  endtask

  task automatic test_size_register();
    dflm_pkg::result_t r;
    write_size_reg(dflm_pkg::COUNT_W'(1));
    do_pop(r);
    do_pop(r);
    do_add(1, 1'b1, r);
    do_free(dflm_pkg::PTR_W'(0), r);
    do_free(dflm_pkg::PTR_W'(1), r);
    write_size_reg(dflm_pkg::COUNT_W'(0));
    do_pop(r);
    write_size_reg(dflm_pkg::COUNT_W'(511));
    do_free(dflm_pkg::PTR_W'(255), r);
    do_pop(r);
    write_size_reg(dflm_pkg::COUNT_W'(300));
    do_pop(r);
  endtask

  task automatic test_chain_corners();
    dflm_pkg::result_t r;
    // The chain count under-reserves, so the list empties part way through.
    write_size_reg(dflm_pkg::COUNT_W'(2));
    do_add(1, 1'b0, r);
    do_add(1, 1'b0, r);
    do_add(1, 1'b0, r);
    do_add(1, 1'b1, r);
    do_free(dflm_pkg::PTR_W'(0), r);
    // Freeing the head links it to itself; a NEXT-flagged self link then makes
    // the walk stop only at the size limit.
    write_size_reg(dflm_pkg::COUNT_W'(4));
    do_free(dflm_pkg::PTR_W'(0), r);
    do_add(1, 1'b0, r);
    do_free(dflm_pkg::PTR_W'(0), r);
    do_pop(r);
    do_add(1, 1'b1, r);
    // A pop in the middle of an add chain.
    write_size_reg(dflm_pkg::COUNT_W'(4));
    do_add(2, 1'b0, r);
    do_pop(r);
    do_add(2, 1'b1, r);
    do_free(dflm_pkg::PTR_W'(0), r);
  endtask

  task automatic test_input_backpressure();
    dflm_pkg::result_t r;
    int                i;
    write_size_reg(dflm_pkg::COUNT_W'(256));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    hold_left = 150;
    for (i = 0; i < 24; i++) begin
      if (i % 2 == 1) begin
        do_pop(r);
      end else begin
        do_add(1, 1'b1, r);
      end
    end
    wait_for_results();
  endtask

  task automatic random_traffic(input int size_val, input int n_items);
    dflm_pkg::result_t r;
    int                stop_at;
    int                pick;
    int                k;
    int                cc;
    int                s;
    write_size_reg(dflm_pkg::COUNT_W'(size_val));
    s       = active_size();
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        k = ($urandom_range(9) == 0) ? $urandom_range(1, (s < 40) ? s : 40)
                                     : $urandom_range(1, 4);
        case ($urandom_range(15))
          0:       cc = $urandom_range(256);
          1:       cc = k - 1;
          2, 3:    cc = k + $urandom_range(1, 3);
          default: cc = k;
        endcase
        add_chain(k, cc);
      end else if (pick < 70) begin
        free_live();
      end else if (pick < 82) begin
        do_pop(r);
      end else begin
        send_noise();
      end
    end
  endtask

  initial begin
    rebuild_table(dflm_pkg::COUNT_W'(256));
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_size_register();
    test_chain_corners();
    test_input_backpressure();

    send_idle_pct = 27;
    recv_idle_pct = 51;
    random_traffic(8, 70);
    random_traffic(256, 50);
    send_idle_pct = 51;
    recv_idle_pct = 27;
    random_traffic(3, 50);
    random_traffic($urandom_range(20, 200), 50);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_traffic(16, 70);
    random_traffic(2, 50);

    wait_for_results();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                pending_results.size()));
    end
    $display("Covered %0d items over %0d queue size settings; %0d results compared.",
             items_sent, sizes_used, results_checked);
    $display("Result mix: %0d ok, %0d rejected or empty, %0d out of range; %0d mismatches.",
             count_ok, count_empty, count_range, error_count);
    if (error_count == 0) begin
      $display("tb_descriptor_free_list_manager_core: done, clean");
    end else begin
      $display("tb_descriptor_free_list_manager_core: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/dflm_pkg.sv
rtl/core/dflm_table.sv
rtl/core/dflm_walk_buf.sv
rtl/core/dflm_ctrl.sv
rtl/core/descriptor_free_list_manager_core.sv
dv/tb_descriptor_free_list_manager_core.sv
